// File: sv/tilt_complementary_filter_core_defines.svh
// Assertion macros used by the checker file tcf_checker.sv.
// No dependencies.
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_DEFINES_SVH
// implication checked every clock, quiet in reset
`define TCF_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define TCF_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: sv/tcf_pkg.sv
// Package for the tilt complementary filter: widths, constants, CORDIC table.
// No dependencies.
package tcf_pkg;
    localparam int CordicSteps = 16;
    localparam int AngW = 18;
    localparam int AngMax = 131071;
    localparam int CordW = 34;
    localparam int ZW = 26;
    localparam int QDepth = 2;

    // ceil(2^47 / 15625): exact quotient for dividends below 2^33
    localparam logic [33:0] DivRecip = 34'd9007199255;
    localparam int DivShift = 47;

    localparam logic [2:0] REG_ALPHA = 3'd0;
    localparam logic [2:0] REG_OFFX = 3'd1;
    localparam logic [2:0] REG_OFFY = 3'd2;
    localparam logic [2:0] REG_DTDEF = 3'd3;
    localparam logic [2:0] REG_DTMAX = 3'd4;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [18:0] gx;
        logic signed [18:0] gy;
        logic [19:0]        dt;
        logic               subst;
    } tcf_job_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ1, ST_SQ2, ST_SQRT, ST_RPRE, ST_RITER,
        ST_PPRE, ST_PITER, ST_GMUL, ST_GMAG, ST_GREC, ST_GDIV,
        ST_BLEND1, ST_BLEND2, ST_OUT
    } tcf_state_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0: r = 2949120; 5'd1: r = 1740967; 5'd2: r = 919879;
                5'd3: r = 466945;  5'd4: r = 234379;  5'd5: r = 117304;
                5'd6: r = 58666;   5'd7: r = 29335;   5'd8: r = 14668;
                5'd9: r = 7334;    5'd10: r = 3667;   5'd11: r = 1833;
                5'd12: r = 917;    5'd13: r = 458;    5'd14: r = 229;
                5'd15: r = 115;    5'd16: r = 57;     5'd17: r = 29;
                5'd18: r = 14;     5'd19: r = 7;      5'd20: r = 4;
                5'd21: r = 2;      5'd22: r = 1;      default: r = 0;
            endcase
            return r;
        end
    endfunction
endpackage

// File: sv/tcf_front.sv
// Front end: config registers, step-time measurement, job formation.
// Depends on tcf_pkg.
module tcf_front import tcf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [17:0] s_rate_x,
    input  logic signed [17:0] s_rate_y,
    input  logic [31:0]        s_timestamp_us,
    output logic [15:0]        alpha,
    output logic               job_valid,
    input  logic               job_ready,
    output tcf_job_t           job
);
    logic [15:0] alpha_reg;
    logic signed [17:0] offx_reg, offy_reg;
    logic [19:0] dtdef_reg, dtmax_reg;
    logic [31:0] last_reg;
    logic [31:0] diff;
    logic bad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= 16'd64225;
            offx_reg <= '0;
            offy_reg <= '0;
            dtdef_reg <= 20'd10000;
            dtmax_reg <= 20'd100000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ALPHA: alpha_reg <= cfg_wdata[15:0];
                REG_OFFX:  offx_reg <= cfg_wdata[17:0];
                REG_OFFY:  offy_reg <= cfg_wdata[17:0];
                REG_DTDEF: dtdef_reg <= cfg_wdata;
                REG_DTMAX: dtmax_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = job_ready;
    assign job_valid = s_valid;
    assign alpha = alpha_reg;
    assign diff = s_timestamp_us - last_reg;
    assign bad = (diff == 32'd0) || (diff > {12'd0, dtmax_reg});

    always_comb begin
        job.cmd = s_command;
        job.ax = s_accel_x;
        job.ay = s_accel_y;
        job.az = s_accel_z;
        job.gx = 19'(s_rate_x) - 19'(offx_reg);
        job.gy = 19'(s_rate_y) - 19'(offy_reg);
        job.dt = bad ? dtdef_reg : diff[19:0];
        job.subst = bad & ~s_command;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) last_reg <= '0;
        else if (s_valid && s_ready) last_reg <= s_timestamp_us;
    end
endmodule

// File: sv/tcf_queue.sv
// Short job queue between front and back ends.
// Depends on tcf_pkg.
module tcf_queue import tcf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  tcf_job_t in_job,
    output logic     out_valid,
    input  logic     out_ready,
    output tcf_job_t out_job
);
    tcf_job_t mem_reg [QDepth];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != 2'(QDepth);
    assign out_valid = cnt_reg != 2'd0;
    assign out_job = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: sv/tcf_back.sv
// Back end: sqrt, shared CORDIC, gyro integration, blend, result register.
// Depends on tcf_pkg.
module tcf_back import tcf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         alpha,
    input  logic                job_valid,
    output logic                job_ready,
    input  tcf_job_t            job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [17:0]  m_roll_angle,
    output logic signed [17:0]  m_pitch_angle,
    output logic                m_dt_substituted
);
    tcf_state_t st_reg, st_next;
    tcf_job_t j_reg;
    logic [33:0] sq_reg;
    logic [49:0] n_reg, res_reg, bit_reg;
    logic signed [CordW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0] it_reg;
    logic signed [17:0] ar_reg, ap_reg, roll_reg, pitch_reg;
    logic signed [43:0] prod_reg;
    logic [43:0] mag_reg, q_reg;
    logic [49:0] rlo_reg, rhi_reg;
    logic roll_ph_reg;
    logic signed [36:0] bl_reg;
    logic signed [17:0] oroll_reg, opitch_reg;
    logic osub_reg, ov_reg;

    logic [49:0] trial;
    logic signed [CordW-1:0] dx, dy, y0, x0;
    logic signed [ZW-1:0] zr;
    logic signed [19:0] pred;
    logic signed [17:0] acc, sat;
    logic signed [36:0] bl_sum;
    logic signed [20:0] blend_res;
    logic signed [44:0] inc;

    assign job_ready = (st_reg == ST_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_roll_angle = oroll_reg;
    assign m_pitch_angle = opitch_reg;
    assign m_dt_substituted = osub_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:   if (job_valid && job_ready) st_next = ST_SQ1;
            ST_SQ1:    st_next = ST_SQ2;
            ST_SQ2:    st_next = ST_SQRT;
            ST_SQRT:   if (bit_reg == '0) st_next = ST_RPRE;
            ST_RPRE:   st_next = ST_RITER;
            ST_RITER:  if (it_reg == 5'(CordicSteps)) st_next = ST_PPRE;
            ST_PPRE:   st_next = ST_PITER;
            ST_PITER:  if (it_reg == 5'(CordicSteps))
                           st_next = j_reg.cmd ? ST_OUT : ST_GMUL;
            ST_GMUL:   st_next = ST_GMAG;
            ST_GMAG:   st_next = ST_GREC;
            ST_GREC:   st_next = ST_GDIV;
            ST_GDIV:   st_next = ST_BLEND1;
            ST_BLEND1: st_next = ST_BLEND2;
            ST_BLEND2: st_next = roll_ph_reg ? ST_GMUL : ST_OUT;
            ST_OUT:    if (!ov_reg) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    // restoring square root step
    assign trial = res_reg + bit_reg;
    // CORDIC step
    assign dx = x_reg >>> it_reg;
    assign dy = y_reg >>> it_reg;
    assign zr = (z_reg + ZW'(128)) >>> 8;
    // blend
    assign pred = 20'(roll_ph_reg ? roll_reg : pitch_reg) + 20'(inc);
    assign inc = prod_reg[43] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign acc = roll_ph_reg ? ar_reg : ap_reg;
    assign bl_sum = bl_reg + 37'(32768);
    assign blend_res = 21'(bl_sum >>> 16);
    assign sat = (blend_res > 21'sd131071) ? 18'sd131071 :
                 (blend_res < -21'sd131071) ? -18'sd131071 : blend_res[17:0];

    always_comb begin
        x0 = '0;
        y0 = '0;
        if (st_reg == ST_RPRE) begin
            x0 = CordW'(j_reg.az) <<< 8;
            y0 = CordW'(j_reg.ay) <<< 8;
        end else begin
            x0 = CordW'({1'b0, res_reg[32:0]});
            y0 = -(CordW'(j_reg.ax) <<< 8);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            roll_reg <= '0;
            pitch_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            if (st_reg == ST_OUT && !ov_reg) begin
                ov_reg <= 1'b1;
                oroll_reg <= roll_reg;
                opitch_reg <= pitch_reg;
                osub_reg <= j_reg.subst;
            end
            if (st_reg == ST_PITER && st_next == ST_OUT) begin
                roll_reg <= ar_reg;
                pitch_reg <= 18'(zr);
            end
            if (st_reg == ST_BLEND2) begin
                if (roll_ph_reg) roll_reg <= sat;
                else pitch_reg <= sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            ST_IDLE: begin
                j_reg <= job;
                sq_reg <= 34'($signed(job.ay) * $signed(job.ay));
                roll_ph_reg <= 1'b1;
            end
            ST_SQ1: sq_reg <= sq_reg + 34'($signed(j_reg.az) * $signed(j_reg.az));
            ST_SQ2: begin
                n_reg <= {sq_reg[31:0], 16'd0, 2'b00} >> 2;
                res_reg <= '0;
                bit_reg <= 50'd1 << 48;
            end
            ST_SQRT: begin
                if (bit_reg != '0) begin
                    if (n_reg >= trial) begin
                        n_reg <= n_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            ST_RPRE, ST_PPRE: begin
                it_reg <= '0;
                if (x0 < 0) begin
                    if (y0 >= 0) begin
                        x_reg <= y0; y_reg <= -x0; z_reg <= ZW'(90 * 65536);
                    end else begin
                        x_reg <= -y0; y_reg <= x0; z_reg <= -ZW'(90 * 65536);
                    end
                end else begin
                    x_reg <= x0; y_reg <= y0; z_reg <= '0;
                end
                if (x0 == 0 && y0 == 0) it_reg <= 5'(CordicSteps);
            end
            ST_RITER, ST_PITER: begin
                if (it_reg != 5'(CordicSteps)) begin
                    if (y_reg > 0) begin
                        x_reg <= x_reg + dy; y_reg <= y_reg - dx;
                        z_reg <= z_reg + atan_entry(it_reg);
                    end else begin
                        x_reg <= x_reg - dy; y_reg <= y_reg + dx;
                        z_reg <= z_reg - atan_entry(it_reg);
                    end
                    it_reg <= it_reg + 5'd1;
                end else if (st_reg == ST_RITER) begin
                    ar_reg <= 18'(zr);
                end else begin
                    ap_reg <= 18'(zr);
                end
            end
            ST_GMUL: begin
                prod_reg <= 44'((roll_ph_reg ? j_reg.gx : j_reg.gy)
                                * $signed({1'b0, j_reg.dt}));
            end
            ST_GMAG: mag_reg <= (prod_reg[43] ? 44'(-prod_reg) : 44'(prod_reg))
                                + 44'd500000;
            ST_GREC: begin
                // n / 1e6 = (n >> 6) / 15625, reciprocal taken in two halves
                rlo_reg <= 50'(mag_reg[38:6] * DivRecip[16:0]);
                rhi_reg <= 50'(mag_reg[38:6] * DivRecip[33:17]);
            end
            ST_GDIV: q_reg <= 44'(({1'b0, rhi_reg, 17'd0} + {18'd0, rlo_reg})
                                  >> DivShift);
            ST_BLEND1: bl_reg <= 37'($signed({1'b0, alpha}) * pred)
                                 + 37'($signed(18'd65536 - {2'b0, alpha}) * acc);
            ST_BLEND2: roll_ph_reg <= 1'b0;
            default: ;
        endcase
    end
endmodule

// File: sv/tilt_complementary_filter_core.sv
// Tilt complementary filter: one result per accepted item, roll and pitch in
// 1/256 degree. A reseed item runs the bit-serial square root and the shared
// 16-step CORDIC twice (roll, then pitch; a zero vector skips its steps); a
// filter step then adds gyro integration and blend per axis (GMUL, GMAG,
// GREC, GDIV, BLEND1, BLEND2), the divide by 1e6 done by reciprocal multiply.
// The back end takes no new item while a result waits. A two-entry queue lets
// the front accept items while the back works.
module tilt_complementary_filter_core import tcf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [17:0] s_rate_x,
    input  logic signed [17:0] s_rate_y,
    input  logic [31:0]        s_timestamp_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_roll_angle,
    output logic signed [17:0] m_pitch_angle,
    output logic               m_dt_substituted
);
    tcf_job_t fj, bj;
    logic fv, fr, bv, br;
    logic [15:0] alpha;

    tcf_front u_front (.aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_command, .s_accel_x, .s_accel_y, .s_accel_z,
        .s_rate_x, .s_rate_y, .s_timestamp_us, .alpha,
        .job_valid(fv), .job_ready(fr), .job(fj));
    tcf_queue u_queue (.aclk, .aresetn, .in_valid(fv), .in_ready(fr), .in_job(fj),
        .out_valid(bv), .out_ready(br), .out_job(bj));
    tcf_back u_back (.aclk, .aresetn, .alpha, .job_valid(bv), .job_ready(br),
        .job(bj), .m_valid, .m_ready, .m_roll_angle, .m_pitch_angle,
        .m_dt_substituted);
endmodule

// File: sv/tcf_checker.sv
// Port-level checker for the tilt complementary filter core, with bind.
// Depends on tilt_complementary_filter_core_defines.svh.
`include "tilt_complementary_filter_core_defines.svh"
module tcf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [17:0] m_roll_angle,
    input logic signed [17:0] m_pitch_angle
);
    `TCF_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `TCF_ASSERT_IMP(a_roll, aclk, aresetn, m_valid, m_roll_angle != -18'sd131072)
    `TCF_ASSERT_IMP(a_pitch, aclk, aresetn, m_valid, m_pitch_angle != -18'sd131072)
endmodule

bind tilt_complementary_filter_core tcf_checker u_tcf_checker (.aclk, .aresetn,
    .m_valid, .m_ready, .m_roll_angle, .m_pitch_angle);

// File: bench/tilt_complementary_filter_core_test.sv
// Self-checking bench for tilt_complementary_filter_core: directed and random
// IMU samples checked against an in-bench fixed-point filter model.
// Depends on tcf_pkg and the core RTL only.
module tilt_complementary_filter_core_test import tcf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1500000;
    localparam logic [2:0] RegUnused = 3'd7;

    typedef struct {
        logic signed [17:0] roll;
        logic signed [17:0] pitch;
        logic               subst;
    } tilt_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = REG_ALPHA;
    logic [19:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_command = 1'b0;
    logic signed [15:0] s_accel_x = '0;
    logic signed [15:0] s_accel_y = '0;
    logic signed [15:0] s_accel_z = '0;
    logic signed [17:0] s_rate_x = '0;
    logic signed [17:0] s_rate_y = '0;
    logic [31:0]        s_timestamp_us = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [17:0] m_roll_angle;
    logic signed [17:0] m_pitch_angle;
    logic               m_dt_substituted;

    tilt_complementary_filter_core u_top (.*);

    // filter model state and registers
    logic [15:0]        mdl_alpha;
    logic signed [17:0] mdl_off_x;
    logic signed [17:0] mdl_off_y;
    logic [19:0]        mdl_dt_def;
    logic [19:0]        mdl_dt_max;
    longint             mdl_roll;
    longint             mdl_pitch;
    logic [31:0]        mdl_last_ts;

    tilt_result_t pending_angles[$];
    int  error_count = 0;
    int  result_count = 0;
    int  item_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic [31:0] ts_now = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint tilt_atan2(input longint y_in, input longint x_in);
        longint tab [0:23];
        longint x, y, z, t, dx, dy;
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115,
                57, 29, 14, 7, 4, 2, 1, 0};
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < CordicSteps; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x += dy; y -= dx; z += tab[i];
            end else begin
                x -= dy; y += dx; z -= tab[i];
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic longint root_of(input logic [63:0] n_in);
        logic [63:0] n, res, bits;
        n = n_in;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > n) bits >>= 2;
        while (bits != 0) begin
            if (n >= res + bits) begin
                n -= res + bits;
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint clamp_angle(input longint v);
        if (v > AngMax) return AngMax;
        if (v < -AngMax) return -AngMax;
        return v;
    endfunction

    function automatic longint rate_increment(input longint g, input longint dt);
        longint p, q;
        p = g * dt;
        q = ((p < 0 ? -p : p) + 500000) / 1000000;
        return p < 0 ? -q : q;
    endfunction

    function automatic longint blend_angle(input longint pred, input longint acc);
        longint a;
        a = longint'(mdl_alpha);
        return clamp_angle((a * pred + (65536 - a) * acc + 32768) >>> 16);
    endfunction

    task automatic advance_filter(input logic cmd, input logic signed [15:0] ax,
                                  input logic signed [15:0] ay,
                                  input logic signed [15:0] az,
                                  input logic signed [17:0] rx,
                                  input logic signed [17:0] ry,
                                  input logic [31:0] ts);
        longint yl, zl, acc_roll, acc_pitch, dt;
        logic [31:0] delta;
        tilt_result_t r;
        yl = longint'(ay);
        zl = longint'(az);
        acc_roll = tilt_atan2(yl * 256, zl * 256);
        acc_pitch = tilt_atan2(-longint'(ax) * 256,
                               root_of(64'(yl * yl + zl * zl) << 16));
        r.subst = 1'b0;
        if (cmd) begin
            mdl_roll = clamp_angle(acc_roll);
            mdl_pitch = clamp_angle(acc_pitch);
        end else begin
            delta = ts - mdl_last_ts;
            dt = longint'(delta);
            if (delta == 0 || dt > longint'(mdl_dt_max)) begin
                dt = longint'(mdl_dt_def);
                r.subst = 1'b1;
            end
            mdl_roll = blend_angle(mdl_roll + rate_increment(longint'(rx) -
                                   longint'(mdl_off_x), dt), acc_roll);
            mdl_pitch = blend_angle(mdl_pitch + rate_increment(longint'(ry) -
                                    longint'(mdl_off_y), dt), acc_pitch);
        end
        mdl_last_ts = ts;
        r.roll = mdl_roll[17:0];
        r.pitch = mdl_pitch[17:0];
        pending_angles.push_back(r);
    endtask

    task automatic send_sample(input logic cmd, input logic signed [15:0] ax,
                               input logic signed [15:0] ay,
                               input logic signed [15:0] az,
                               input logic signed [17:0] rx,
                               input logic signed [17:0] ry,
                               input logic [31:0] ts);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_accel_x <= ax;
        s_accel_y <= ay;
        s_accel_z <= az;
        s_rate_x <= rx;
        s_rate_y <= ry;
        s_timestamp_us <= ts;
        do @(posedge aclk); while (!s_ready);
        advance_filter(cmd, ax, ay, az, rx, ry, ts);
        item_count++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ALPHA: mdl_alpha = val[15:0];
            REG_OFFX:  mdl_off_x = val[17:0];
            REG_OFFY:  mdl_off_y = val[17:0];
            REG_DTDEF: mdl_dt_def = val;
            REG_DTMAX: mdl_dt_max = val;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch %s: got %0d expected %0d (result %0d)",
                     what, got, want, result_count);
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        tilt_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL tilt_complementary_filter_core");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_angles.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = pending_angles.pop_front();
                if (m_roll_angle !== want.roll)
                    report_mismatch("roll", m_roll_angle, want.roll);
                if (m_pitch_angle !== want.pitch)
                    report_mismatch("pitch", m_pitch_angle, want.pitch);
                if (m_dt_substituted !== want.subst)
                    report_mismatch("dt_substituted", m_dt_substituted, want.subst);
            end
            result_count++;
        end
    end

    function automatic logic [31:0] next_stamp(input logic [31:0] prev);
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return prev + $urandom_range(1, int'(mdl_dt_max) + 1);
        if (pick < 80) return prev;
        if (pick < 90) return prev + mdl_dt_max + $urandom_range(1, 5000000);
        return $urandom;
    endfunction

    task automatic test_directed_extremes();
        send_sample(1'b0, 0, 0, 0, 0, 0, 32'd0);
        send_sample(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 18'sh1FFFF, 18'sh1FFFF,
                    32'd5000);
        send_sample(1'b0, -16'sh8000, -16'sh8000, -16'sh8000, -18'sh20000,
                    -18'sh20000, 32'd15000);
        send_sample(1'b1, 16'sh1234, -16'sh8000, 16'sh7FFF, 0, 0, 32'd20000);
        send_sample(1'b0, 0, 16'sh4000, -16'sh4000, 18'sh00100, -18'sh00100,
                    32'd20000);
        send_sample(1'b0, 16'sh7FFF, 0, -16'sh0001, 0, 0, 32'd20000 + 100001);
        send_sample(1'b0, -16'sh0001, 16'sh0001, 0, 0, 0, 32'd20000 + 200001);
        send_sample(1'b1, 0, 0, 0, 18'sh1FFFF, -18'sh20000, 32'hFFFF_FFF0);
        send_sample(1'b0, 16'sh0100, 16'sh0200, 16'sh4000, 18'sh01000, 18'sh02000,
                    32'd100);
        send_sample(1'b0, 0, 0, 16'sh4000, 0, 0, 32'hFFFF_FFFF);
        send_sample(1'b1, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 0, 0, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_saturation();
        write_reg(REG_ALPHA, 20'hFFFFF);
        write_reg(REG_OFFX, 20'h20000);
        write_reg(REG_OFFY, 20'h1FFFF);
        write_reg(REG_DTDEF, 20'hFFFFF);
        write_reg(REG_DTMAX, 20'hFFFFF);
        for (int i = 0; i < 4; i++)
            send_sample(1'b0, 0, 0, 16'sh4000, 18'sh1FFFF, -18'sh20000, ts_now);
        for (int i = 0; i < 3; i++)
            send_sample(1'b0, 0, 0, 16'sh4000, -18'sh20000, 18'sh1FFFF, ts_now);
        wait_idle();
        write_reg(REG_ALPHA, 20'd0);
        write_reg(REG_DTDEF, 20'd0);
        write_reg(REG_DTMAX, 20'd1);
        send_sample(1'b0, 16'sh7FFF, -16'sh8000, 16'sh0010, 18'sh1FFFF, 0, ts_now);
        send_sample(1'b0, -16'sh8000, 0, 16'sh0010, 0, 18'sh1FFFF, ts_now + 1);
        send_sample(1'b0, 0, 16'sh7FFF, 0, 0, 0, ts_now + 3);
        wait_idle();
    endtask

    task automatic randomise_config(input bit extreme);
        if (extreme) begin
            write_reg(REG_ALPHA, $urandom_range(1) ? 20'hFFFF : 20'h0);
            write_reg(REG_OFFX, $urandom_range(1) ? 20'h1FFFF : 20'hE0000);
            write_reg(REG_OFFY, $urandom_range(1) ? 20'h1FFFF : 20'h20000);
            write_reg(REG_DTDEF, $urandom_range(1) ? 20'hFFFFF : 20'd1);
            write_reg(REG_DTMAX, $urandom_range(1) ? 20'hFFFFF : 20'd1);
        end else begin
            write_reg(REG_ALPHA, 20'($urandom));
            write_reg(REG_OFFX, $urandom_range(1) ? 20'($urandom)
                                                  : 20'($urandom_range(2000)));
            write_reg(REG_OFFY, $urandom_range(1) ? 20'($urandom)
                                                  : 20'($urandom_range(2000)));
            write_reg(REG_DTDEF, 20'($urandom_range(1, 1048575)));
            write_reg(REG_DTMAX, $urandom_range(1) ? 20'($urandom_range(1, 1048575))
                                                   : 20'($urandom_range(1000, 200000)));
        end
    endtask

    task automatic test_random_stream(input int count, input int idle_pct,
                                      input int stall_pct);
        logic signed [17:0] rx, ry;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            ts_now = next_stamp(ts_now);
            if ($urandom_range(3) == 0) begin
                rx = 18'($urandom);
                ry = 18'($urandom);
            end else begin
                rx = mdl_off_x + $signed(18'($urandom_range(4000))) - 18'sd2000;
                ry = mdl_off_y + $signed(18'($urandom_range(4000))) - 18'sd2000;
            end
            send_sample($urandom_range(19) == 0, 16'($urandom), 16'($urandom),
                        16'($urandom), rx, ry, ts_now);
        end
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        mdl_alpha = 16'd64225;
        mdl_off_x = '0;
        mdl_off_y = '0;
        mdl_dt_def = 20'd10000;
        mdl_dt_max = 20'd100000;
        mdl_roll = 0;
        mdl_pitch = 0;
        mdl_last_ts = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_extremes();
        test_saturation();
        write_reg(RegUnused, 20'hABCDE);
        randomise_config(1'b0);
        test_random_stream(300, 0, 0);
        randomise_config(1'b1);
        test_random_stream(150, 80, 0);
        randomise_config(1'b0);
        test_random_stream(300, 0, 80);
        randomise_config(1'b1);
        test_random_stream(150, 16, 16);
        randomise_config(1'b0);
        test_random_stream(350, 16, 16);
        write_reg(REG_ALPHA, 20'd64225);
        write_reg(REG_OFFX, 20'd0);
        write_reg(REG_OFFY, 20'd0);
        write_reg(REG_DTDEF, 20'd10000);
        write_reg(REG_DTMAX, 20'd100000);
        test_random_stream(80, 50, 50);

        $display("covered %0d items and %0d results over directed, saturation",
                 item_count, result_count);
        $display("and random phases with varied registers and handshake pressure");
        if (error_count == 0 && pending_angles.size() == 0) begin
            $display("PASS tilt_complementary_filter_core");
        end else begin
            $display("FAIL tilt_complementary_filter_core");
        end
        $finish;
    end
endmodule

// File: tilt_complementary_filter_core.f
+incdir+sv
sv/tcf_pkg.sv
sv/tcf_front.sv
sv/tcf_queue.sv
sv/tcf_back.sv
sv/tilt_complementary_filter_core.sv
sv/tcf_checker.sv
bench/tilt_complementary_filter_core_test.sv
